// ----- hdl/itss_pkg.sv -----
`timescale 1ns / 1ps
package itss_pkg;

	localparam int KEY_BITS    = 16;
	localparam int IN_REF_BITS = 32;
	localparam int CNT_BITS    = 9;

	// item kinds (s_axis_tuser)
	localparam logic [1:0] MODE_APPEND = 2'd0;
	localparam logic [1:0] MODE_SORT   = 2'd1;
	localparam logic [1:0] MODE_LOOKUP = 2'd2;

	// result status (m_axis_tuser)
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic item_ld;    // latch request fields, result defaults to ok / zero
		logic app_wr;     // append at fill count, or flag full
		logic lk_init;    // search bounds over the whole table
		logic lk_rd;      // read entry at midpoint
		logic lk_step;    // compare midpoint key, narrow bounds
		logic so_init;    // unsorted prefix = whole table
		logic scan_start; // restart scan at entry zero
		logic scan_rd;    // read next scan entry
		logic swap1;      // write prefix maximum to prefix end
		logic swap2;      // write old end entry where the maximum was
		logic out_ld;     // move result into output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] mode;
		logic       lk_live;   // search range not empty
		logic       lk_hit;    // key at midpoint matches
		logic       pass_live; // unsorted prefix holds two or more entries
		logic       scan_last; // scan address is the prefix end
	} stat_t;

endpackage

// ----- hdl/itss_ctrl.sv -----
`timescale 1ns / 1ps
module itss_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output itss_pkg::cmd_t     cmd,
	input  itss_pkg::stat_t    stat
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_APPEND,
		S_LK_PROBE,
		S_LK_CMP,
		S_SO_PASS,
		S_SO_SCAN,
		S_SO_DRAIN,
		S_SO_SWAP1,
		S_SO_SWAP2,
		S_DONE
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   out_valid_q;
	logic   slot_free;
	logic   accept;

	assign in_ready  = ready_q;
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;
	assign accept    = in_valid && ready_q;

	always_comb begin
		cmd            = '0;
		cmd.item_ld    = (state_q == S_IDLE) && accept;
		cmd.app_wr     = (state_q == S_APPEND);
		cmd.lk_init    = (state_q == S_DISPATCH) && (stat.mode == itss_pkg::MODE_LOOKUP);
		cmd.so_init    = (state_q == S_DISPATCH) && (stat.mode == itss_pkg::MODE_SORT);
		cmd.lk_rd      = (state_q == S_LK_PROBE) && stat.lk_live;
		cmd.lk_step    = (state_q == S_LK_CMP);
		cmd.scan_start = (state_q == S_SO_PASS) && stat.pass_live;
		cmd.scan_rd    = (state_q == S_SO_SCAN);
		cmd.swap1      = (state_q == S_SO_SWAP1);
		cmd.swap2      = (state_q == S_SO_SWAP2);
		cmd.out_ld     = (state_q == S_DONE) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ready_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			// set on result load, cleared once taken
			out_valid_q <= cmd.out_ld || (out_valid_q && !out_ready);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						ready_q <= 1'b0;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					unique case (stat.mode)
						itss_pkg::MODE_APPEND: state_q <= S_APPEND;
						itss_pkg::MODE_SORT:   state_q <= S_SO_PASS;
						itss_pkg::MODE_LOOKUP: state_q <= S_LK_PROBE;
						default:               state_q <= S_DONE;
					endcase
				end
				S_APPEND:   state_q <= S_DONE;
				S_LK_PROBE: state_q <= stat.lk_live ? S_LK_CMP : S_DONE;
				S_LK_CMP:   state_q <= stat.lk_hit ? S_DONE : S_LK_PROBE;
				S_SO_PASS:  state_q <= stat.pass_live ? S_SO_SCAN : S_DONE;
				S_SO_SCAN: begin
					if (stat.scan_last)
						state_q <= S_SO_DRAIN;
				end
				S_SO_DRAIN: state_q <= S_SO_SWAP1;
				S_SO_SWAP1: state_q <= S_SO_SWAP2;
				S_SO_SWAP2: state_q <= S_SO_PASS;
				S_DONE: begin
					if (slot_free) begin
						ready_q     <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// one request in flight at a time
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> state_q == S_IDLE)
		else $error("request taken outside idle");

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_DISPATCH && !ready_q)
		else $error("accepted request not dispatched");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |=> out_valid_q && ready_q)
		else $error("result load lost");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !cmd.out_ld)
		else $error("pending result overwritten");

endmodule

// ----- hdl/itss_dpath.sv -----
`timescale 1ns / 1ps
module itss_dpath #(
	parameter int DEPTH    = 256,
	parameter int REF_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [1:0]                         in_mode,
	input  logic [itss_pkg::KEY_BITS-1:0]      in_key,
	input  logic [itss_pkg::IN_REF_BITS-1:0]   in_ref,
	input  itss_pkg::cmd_t                     cmd,
	output itss_pkg::stat_t                    stat,
	output logic [1:0]                         out_status,
	output logic [itss_pkg::IN_REF_BITS-1:0]   out_ref,
	output logic [itss_pkg::CNT_BITS-1:0]      out_count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int KW = itss_pkg::KEY_BITS;
	localparam int WW = KW + REF_BITS;
	localparam int XW = REF_BITS + itss_pkg::IN_REF_BITS;
	localparam int NW = CW + itss_pkg::CNT_BITS;

	logic [WW-1:0] mem [DEPTH];

	logic [1:0]          mode_q;
	logic [KW-1:0]       key_q;
	logic [REF_BITS-1:0] ref_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       lo_q;
	logic [CW-1:0]       hix_q;      // one past the search upper bound
	logic [AW-1:0]       mid_q;
	logic [CW-1:0]       last_q;     // unsorted prefix length
	logic [AW-1:0]       scan_idx_q;
	logic                scan_vld_s1;
	logic [AW-1:0]       scan_idx_s1;
	logic [AW-1:0]       best_idx_q;
	logic [WW-1:0]       best_word_q;
	logic [WW-1:0]       end_word_q;
	logic [WW-1:0]       rd_word_q;
	logic [1:0]          res_status_q;
	logic [REF_BITS-1:0] res_ref_q;
	logic [1:0]          out_status_q;
	logic [itss_pkg::IN_REF_BITS-1:0] out_ref_q;
	logic [itss_pkg::CNT_BITS-1:0]    out_count_q;

	logic [XW-1:0]       in_ref_x;
	logic [XW-1:0]       res_ref_x;
	logic [NW-1:0]       count_x;
	logic [CW:0]         mid_sum;
	logic [AW-1:0]       mid;
	logic [CW-1:0]       end_cnt;
	logic [AW-1:0]       end_idx;
	logic                full;
	logic [KW-1:0]       rd_key;
	logic [REF_BITS-1:0] rd_ref;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [WW-1:0]       wr_word;
	logic [AW-1:0]       rd_addr;

	assign in_ref_x  = XW'(in_ref);
	assign res_ref_x = XW'(res_ref_q);
	assign count_x   = NW'(count_q);
	assign mid_sum   = {1'b0, lo_q} + {1'b0, hix_q} - (CW + 1)'(1);
	assign mid       = mid_sum[AW:1];
	assign end_cnt   = last_q - CW'(1);
	assign end_idx   = end_cnt[AW-1:0];
	assign full      = (count_q == CW'(DEPTH));
	assign rd_key    = rd_word_q[KW-1:0];
	assign rd_ref    = rd_word_q[WW-1:KW];

	assign stat.mode      = mode_q;
	assign stat.lk_live   = (lo_q < hix_q);
	assign stat.lk_hit    = (rd_key == key_q);
	assign stat.pass_live = (last_q > CW'(1));
	assign stat.scan_last = (scan_idx_q == end_idx);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[AW-1:0];
		wr_word = {ref_q, key_q};
		if (cmd.app_wr) begin
			wr_en = !full;
		end else if (cmd.swap1) begin
			wr_en   = 1'b1;
			wr_addr = end_idx;
			wr_word = best_word_q;
		end else if (cmd.swap2) begin
			wr_en   = 1'b1;
			wr_addr = best_idx_q;
			wr_word = end_word_q;
		end
		rd_addr = cmd.lk_rd ? mid : scan_idx_q;
	end

	// table storage, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_word;
		rd_word_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			scan_vld_s1 <= 1'b0;
		end else begin
			scan_vld_s1 <= cmd.scan_rd;
			if (cmd.app_wr && !full)
				count_q <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		scan_idx_s1 <= scan_idx_q;
		if (cmd.item_ld) begin
			mode_q       <= in_mode;
			key_q        <= in_key;
			ref_q        <= in_ref_x[REF_BITS-1:0];
			res_status_q <= itss_pkg::ST_OK;
			res_ref_q    <= '0;
		end
		if (cmd.app_wr && full)
			res_status_q <= itss_pkg::ST_FULL;
		if (cmd.lk_init) begin
			lo_q         <= '0;
			hix_q        <= count_q;
			res_status_q <= itss_pkg::ST_NOT_FOUND;
		end
		if (cmd.lk_rd)
			mid_q <= mid;
		if (cmd.lk_step) begin
			if (rd_key == key_q) begin
				res_status_q <= itss_pkg::ST_OK;
				res_ref_q    <= rd_ref;
			end else if (key_q < rd_key) begin
				hix_q <= CW'(mid_q);
			end else begin
				lo_q <= CW'(mid_q) + CW'(1);
			end
		end
		if (cmd.so_init)
			last_q <= count_q;
		if (cmd.scan_start)
			scan_idx_q <= '0;
		if (cmd.scan_rd)
			scan_idx_q <= scan_idx_q + AW'(1);
		// first maximum wins: replace only on strictly greater
		if (scan_vld_s1) begin
			if (scan_idx_s1 == '0 || rd_key > best_word_q[KW-1:0]) begin
				best_idx_q  <= scan_idx_s1;
				best_word_q <= rd_word_q;
			end
			if (scan_idx_s1 == end_idx)
				end_word_q <= rd_word_q;
		end
		if (cmd.swap2)
			last_q <= end_cnt;
		if (cmd.out_ld) begin
			out_status_q <= res_status_q;
			out_ref_q    <= res_ref_x[itss_pkg::IN_REF_BITS-1:0];
			out_count_q  <= count_x[itss_pkg::CNT_BITS-1:0];
		end
	end

	assign out_status = out_status_q;
	assign out_ref    = out_ref_q;
	assign out_count  = out_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count beyond depth");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.app_wr && !full |=> count_q == $past(count_q) + CW'(1))
		else $error("append did not grow table");

	a_scan_in_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		scan_vld_s1 |-> CW'(scan_idx_s1) < last_q)
		else $error("scan read beyond unsorted prefix");

	a_probe_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.lk_rd |-> CW'(mid) < count_q)
		else $error("search probe beyond table");

endmodule

// ----- hdl/index_table_sort_and_search.sv -----
`timescale 1ns / 1ps
// channel   dir  tdata (low bit up)                     tuser
// s_axis    in   key[15:0], record_ref[47:16]           mode[1:0]
// m_axis    out  ref_out[31:0], entry_count[40:32]      status[1:0]
//
// Steps: an append writes at the fill count or flags full; an unused mode
//   returns its default result; a lookup makes up to log2(DEPTH)+1 probes
//   (one table read then one compare each); a sort runs passes, each a scan
//   of the unsorted prefix then a swap of its maximum to the prefix end; the single table read port serves all reads.
// One request is worked at a time; s_axis_tready rises again as the result
// enters the output register, so the next request is taken while that
// result still waits on m_axis_tready.
// Reset clears the fill count and control only; table entries are not
// cleared, and only entries below the fill count are ever read.
module index_table_sort_and_search #(
	parameter int DEPTH    = 256,
	parameter int REF_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // key[15:0], record_ref[47:16]
	input  logic [1:0]  s_axis_tuser,   // mode[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // ref_out[31:0], entry_count[40:32], zero fill
	output logic [1:0]  m_axis_tuser    // status[1:0]
);

	itss_pkg::cmd_t  cmd;
	itss_pkg::stat_t stat;

	logic [itss_pkg::IN_REF_BITS-1:0] ref_out;
	logic [itss_pkg::CNT_BITS-1:0]    entry_count;

	// sequencer: request handshake, search and sort steps
	itss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// table memory, fill count, search bounds, scan maximum, result register
	itss_dpath #(
		.DEPTH    (DEPTH),
		.REF_BITS (REF_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_mode    (s_axis_tuser),
		.in_key     (s_axis_tdata[15:0]),
		.in_ref     (s_axis_tdata[47:16]),
		.cmd        (cmd),
		.stat       (stat),
		.out_status (m_axis_tuser),
		.out_ref    (ref_out),
		.out_count  (entry_count)
	);

	assign m_axis_tdata = {7'd0, entry_count, ref_out};

endmodule
